// ===== rtl/core/frame_reassembly_checker_top_assert.svh =====
// assertion macros for the frame reassembly checker
`ifndef FRAME_REASSEMBLY_CHECKER_TOP_ASSERT_SVH
`define FRAME_REASSEMBLY_CHECKER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define FRC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("frc assertion failed");

// next-cycle implication, checked out of reset
`define FRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("frc assertion failed");

`endif

// ===== rtl/core/frc_pkg.sv =====
// shared constants, status codes and item types of the frame reassembly checker
package frc_pkg;

    localparam int RX_BUFFER_BYTES = 1024;
    localparam int BYTES_W         = 11;
    localparam int SUM_W           = BYTES_W + 1;

    localparam logic [BYTES_W-1:0] RX_BYTES  = BYTES_W'(RX_BUFFER_BYTES);
    localparam logic [SUM_W-1:0]   OVF_LIMIT = SUM_W'(RX_BUFFER_BYTES + 4);

    localparam logic [7:0] PAD_MAX   = 8'd16;
    localparam logic [9:0] HDR_BYTES = 10'd4;

    typedef enum logic [3:0] {
        ST_IGNORED   = 4'd0,
        ST_PENDING   = 4'd1,
        ST_COMPLETE  = 4'd2,
        ST_OVERFLOW  = 4'd3,
        ST_BAD_FIRST = 4'd4,
        ST_CONT_MISM = 4'd5,
        ST_ENC_BLOCK = 4'd6,
        ST_NO_KEY    = 4'd7,
        ST_LEN_MISM  = 4'd8,
        ST_TIMEOUT   = 4'd9
    } t_status;

    typedef struct packed {
        logic       func;
        logic [9:0] pdu_length;
        logic [7:0] header_flags_id;
        logic [7:0] header_command;
        logic [7:0] header_frames;
        logic [7:0] header_payload_len;
        logic [7:0] pad_byte;
    } t_frc_item;

    typedef struct packed {
        logic [3:0]         status;
        logic [BYTES_W-1:0] append_offset;
        logic [7:0]         append_len;
        logic [3:0]         message_id;
        logic [7:0]         message_command;
        logic [BYTES_W-1:0] message_bytes;
        logic [4:0]         reply_seq;
    } t_frc_result;

endpackage

// ===== rtl/core/frc_if.sv =====
// valid/ready channels for received frames and for check results
interface frc_in_if;
    import frc_pkg::*;
    logic      valid;
    logic      ready;
    t_frc_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface frc_out_if;
    import frc_pkg::*;
    logic        valid;
    logic        ready;
    t_frc_result payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/frame_reassembly_checker_top.sv =====
// frame reassembly checker: one received frame or timeout per item, one result per item
//
// i_in carries one received frame header (or a timeout event when func is set);
// o_res returns exactly one result per item: status, append offset and length,
// and the current message id, command, byte count and reply sequence.
// i_cfg_we / i_cfg_wdata write key_present; the user must write it only while the block is idle (not enforced).
// An accepted item is held in the input register, then its result in the
// result register (one input register, one result register).
// Throughput: one item every cycle while results are taken
// at once; the header checks and the byte count add sit between the two
// registers, and the reassembly state updates as an item moves across.
// A stalled receiver holds the result register; one more item waits in the
// input register, then i_in.ready drops until the result is taken.
// Synchronous reset clears both valid flags, key_present and the whole
// reassembly state; no clearing pass is needed.
`include "frame_reassembly_checker_top_assert.svh"

module frame_reassembly_checker_top
    import frc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    frc_in_if.sink     i_in,
    frc_out_if.source  o_res
);

    logic               r_key;
    logic               r_in_valid;
    t_frc_item          r_in;
    logic               r_out_valid;
    t_frc_result        r_out;

    logic [3:0]         r_msg_id;
    logic [7:0]         r_cmd;
    logic [3:0]         r_last;
    logic [3:0]         r_seq;
    logic [BYTES_W-1:0] r_bytes;

    logic [3:0]         n_msg_id;
    logic [7:0]         n_cmd;
    logic [3:0]         n_last;
    logic [3:0]         n_seq;
    logic [BYTES_W-1:0] n_bytes;
    t_frc_result        n_out;

    logic               adv;

    // decoded fields
    logic               enc;
    logic [3:0]         hdr_id;
    logic [3:0]         hdr_last;
    logic [3:0]         hdr_seq;
    logic               first;
    logic               ovf;

    logic [3:0]         eff_id;
    logic [7:0]         eff_cmd;
    logic [3:0]         eff_last;
    logic [3:0]         eff_seq;
    logic [BYTES_W-1:0] eff_bytes;
    logic               order_err;

    logic               blk_err;
    logic               key_err;
    logic               len_err;
    logic [BYTES_W-1:0] room;
    logic [7:0]         alen_raw;
    logic [7:0]         alen;
    logic               pad_ok;
    logic [BYTES_W-1:0] new_bytes;
    logic               done;

    assign adv         = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_in.ready  = !r_in_valid || adv;
    assign o_res.valid = r_out_valid;
    assign o_res.payload = r_out;

    always_comb begin
        enc      = r_in.header_flags_id[4];
        hdr_id   = r_in.header_flags_id[3:0];
        hdr_last = r_in.header_frames[7:4];
        hdr_seq  = r_in.header_frames[3:0];
        first    = (r_last == r_seq);
        // payload length plus gathered bytes above the buffer, header bytes folded in
        ovf = ({2'b00, r_in.pdu_length} + {1'b0, r_bytes}) > OVF_LIMIT;

        if (first) begin
            eff_id    = hdr_id;
            eff_cmd   = r_in.header_command;
            eff_last  = hdr_last;
            eff_seq   = '0;
            eff_bytes = '0;
            order_err = (hdr_seq != 4'd0);
        end else begin
            eff_id    = r_msg_id;
            eff_cmd   = r_cmd;
            eff_last  = r_last;
            eff_seq   = hdr_seq;
            eff_bytes = r_bytes;
            order_err = (r_msg_id != hdr_id) || (r_cmd != r_in.header_command)
                     || (r_last != hdr_last) || ((r_seq + 4'd1) != hdr_seq);
        end

        // encrypted payload must be a whole number of 16-byte blocks
        blk_err = enc && (r_in.pdu_length[3:0] != 4'd4);
        key_err = enc && !r_key;
        if (enc) begin
            len_err = r_in.pdu_length < (HDR_BYTES + {2'b00, r_in.header_payload_len});
        end else begin
            len_err = r_in.pdu_length != (HDR_BYTES + {2'b00, r_in.header_payload_len});
        end

        room     = (eff_bytes <= RX_BYTES) ? (RX_BYTES - eff_bytes) : '0;
        alen_raw = ({3'b000, r_in.header_payload_len} < room)
                 ? r_in.header_payload_len : room[7:0];
        pad_ok   = enc && (r_in.pad_byte != 8'd0) && (r_in.pad_byte <= PAD_MAX);
        if (alen_raw != 8'd0 && pad_ok) begin
            alen = (r_in.pad_byte <= alen_raw) ? (alen_raw - r_in.pad_byte) : 8'd0;
        end else begin
            alen = alen_raw;
        end
        new_bytes = eff_bytes + {3'b000, alen};
        done      = (eff_last == eff_seq);

        n_msg_id = r_msg_id;
        n_cmd    = r_cmd;
        n_last   = r_last;
        n_seq    = r_seq;
        n_bytes  = r_bytes;
        n_out    = '0;

        if (r_in.func) begin
            n_out.status = ST_TIMEOUT;
        end else if (r_in.pdu_length == 10'd0) begin
            n_out.status = ST_IGNORED;
        end else if (ovf) begin
            n_out.status = ST_OVERFLOW;
        end else if (order_err) begin
            n_out.status = first ? ST_BAD_FIRST : ST_CONT_MISM;
        end else begin
            // a first frame has already taken its id when a later check fails
            n_msg_id = eff_id;
            if (blk_err) begin
                n_out.status = ST_ENC_BLOCK;
            end else if (key_err) begin
                n_out.status = ST_NO_KEY;
            end else if (len_err) begin
                n_out.status = ST_LEN_MISM;
            end else begin
                n_out.append_offset   = eff_bytes;
                n_out.append_len      = alen;
                n_out.message_id      = eff_id;
                n_out.message_command = eff_cmd;
                n_out.message_bytes   = new_bytes;
                if (done) begin
                    n_out.status    = ST_COMPLETE;
                    n_out.reply_seq = {1'b0, eff_seq} + 5'd1;
                end else begin
                    n_out.status = ST_PENDING;
                    n_cmd        = eff_cmd;
                    n_last       = eff_last;
                    n_seq        = eff_seq;
                    n_bytes      = new_bytes;
                end
            end
        end

        // every status but pending leaves the reassembly cleared (ignored keeps it)
        if (n_out.status != ST_PENDING && n_out.status != ST_IGNORED) begin
            n_cmd   = '0;
            n_last  = '0;
            n_seq   = '0;
            n_bytes = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key       <= 1'b0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_msg_id    <= '0;
            r_cmd       <= '0;
            r_last      <= '0;
            r_seq       <= '0;
            r_bytes     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_key <= i_cfg_wdata;
            end
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_msg_id    <= n_msg_id;
                r_cmd       <= n_cmd;
                r_last      <= n_last;
                r_seq       <= n_seq;
                r_bytes     <= n_bytes;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.payload;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    `FRC_ASSERT_NEXT(a_err_clears, adv && n_out.status >= ST_OVERFLOW,
        r_bytes == '0 && r_seq == 4'd0 && r_last == 4'd0 && r_cmd == 8'd0)
    `FRC_ASSERT_NOW(a_bytes_bound, 1'b1, r_bytes <= RX_BYTES)
    `FRC_ASSERT_NOW(a_count_sum,
        r_out_valid && (r_out.status == ST_PENDING || r_out.status == ST_COMPLETE),
        r_out.message_bytes == r_out.append_offset + {3'b000, r_out.append_len})
    `FRC_ASSERT_NEXT(a_in_held, r_in_valid && !adv, r_in_valid && $stable(r_in))

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench for the frame reassembly checker: frame stimulus, reassembly prediction, result checks
`timescale 1ns / 100ps

module tb_top;
    import frc_pkg::*;

    localparam int HEADER_LEN   = 4;
    localparam int AES_BLOCK    = 16;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 48;
    localparam int HOLD_TRIGGER = 400;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        frame_valid = 1'b0;
    t_frc_item   frame_data  = '0;
    logic        res_ready   = 1'b0;

    frc_in_if  in_ch ();
    frc_out_if res_ch ();

    assign in_ch.valid   = frame_valid;
    assign in_ch.payload = frame_data;
    assign res_ch.ready  = res_ready;

    frame_reassembly_checker_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_res       (res_ch)
    );

    t_frc_item   pending_frames[$];
    t_frc_result expected_results[$];

    // predicted reassembly state
    logic        key_setting = 1'b0;
    logic [3:0]  asm_id   = '0;
    logic [7:0]  asm_cmd  = '0;
    logic [3:0]  asm_last = '0;
    logic [3:0]  asm_seq  = '0;
    int          asm_bytes = 0;

    bit          calm = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_left = 0;
    int          frames_queued = 0;
    int          frames_accepted = 0;
    int          results_checked = 0;
    int          mismatches = 0;
    int          key_writes = 0;
    int          quiet_cycles = 0;
    int          status_count[16];

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_reassembly_state();
        asm_cmd   = '0;
        asm_last  = '0;
        asm_seq   = '0;
        asm_bytes = 0;
    endfunction

    function automatic t_frc_result reassembly_abort(t_status code);
        t_frc_result r;
        r = '0;
        r.status = code;
        clear_reassembly_state();
        return r;
    endfunction

    function automatic t_frc_result frame_outcome(t_frc_item it);
        t_frc_result r;
        logic        enc;
        logic [3:0]  id;
        logic [3:0]  lst;
        logic [3:0]  sq;
        int          plen;
        int          flen;
        int          pad;
        int          room;
        int          alen;
        r = '0;
        if (it.func)
            return reassembly_abort(ST_TIMEOUT);
        plen = int'(it.pdu_length);
        flen = int'(it.header_payload_len);
        pad  = int'(it.pad_byte);
        enc  = it.header_flags_id[4];
        id   = it.header_flags_id[3:0];
        lst  = it.header_frames[7:4];
        sq   = it.header_frames[3:0];
        if (plen == 0)
            return r;
        // short frames go negative here and pass
        if (plen - HEADER_LEN + asm_bytes > RX_BUFFER_BYTES)
            return reassembly_abort(ST_OVERFLOW);
        if (asm_last == asm_seq) begin
            if (sq != 4'd0)
                return reassembly_abort(ST_BAD_FIRST);
            asm_id    = id;
            asm_cmd   = it.header_command;
            asm_last  = lst;
            asm_seq   = '0;
            asm_bytes = 0;
        end else begin
            if (asm_id != id || asm_cmd != it.header_command || asm_last != lst ||
                4'(asm_seq + 4'd1) != sq)
                return reassembly_abort(ST_CONT_MISM);
            asm_seq = sq;
        end
        if (enc) begin
            if (((plen - HEADER_LEN) & (AES_BLOCK - 1)) != 0)
                return reassembly_abort(ST_ENC_BLOCK);
            if (!key_setting)
                return reassembly_abort(ST_NO_KEY);
        end
        if ((!enc && plen != HEADER_LEN + flen) || (enc && plen < HEADER_LEN + flen))
            return reassembly_abort(ST_LEN_MISM);
        room = (asm_bytes <= RX_BUFFER_BYTES) ? RX_BUFFER_BYTES - asm_bytes : 0;
        alen = (flen < room) ? flen : room;
        // only a pad of 1 to 16 is stripped from the tail
        if (alen > 0 && enc && pad >= 1 && pad <= int'(PAD_MAX))
            alen = (pad <= alen) ? alen - pad : 0;
        r.append_offset   = BYTES_W'(asm_bytes);
        asm_bytes         = asm_bytes + alen;
        r.append_len      = 8'(alen);
        r.message_id      = asm_id;
        r.message_command = asm_cmd;
        r.message_bytes   = BYTES_W'(asm_bytes);
        if (asm_last == asm_seq) begin
            r.status    = ST_COMPLETE;
            r.reply_seq = 5'(asm_seq) + 5'd1;
            clear_reassembly_state();
        end else begin
            r.status = ST_PENDING;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at result %0d: %s got 0x%0h want 0x%0h",
                 results_checked, what, got, want);
        mismatches++;
    endtask

    // frame driver
    always @(posedge i_clk) begin : drive_frames
        logic busy;
        busy = frame_valid;
        if (!i_rst_n) begin
            frame_valid <= 1'b0;
        end else begin
            if (frame_valid && in_ch.ready) begin
                expected_results.push_back(frame_outcome(frame_data));
                frames_accepted++;
                busy = 1'b0;
            end
            if (!busy) begin
                if (pending_frames.size() > 0 && (calm || $urandom_range(99) >= 12)) begin
                    frame_valid <= 1'b1;
                    frame_data  <= pending_frames.pop_front();
                end else begin
                    frame_valid <= 1'b0;
                end
            end
        end
    end

    // result receiver, with one long hold-off to back up the pipeline
    always @(posedge i_clk) begin : drain_results
        if (!i_rst_n) begin
            res_ready <= 1'b0;
        end else if (hold_left > 0) begin
            res_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_checked >= HOLD_TRIGGER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            res_ready <= 1'b0;
        end else begin
            res_ready <= calm || $urandom_range(99) >= 12;
        end
    end

    // result monitor
    always @(posedge i_clk) begin : check_results
        t_frc_result got;
        t_frc_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = res_ch.payload;
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing expected, status", 32'(got.status), '0);
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (got.append_offset !== want.append_offset)
                    report_mismatch("append_offset", 32'(got.append_offset),
                                    32'(want.append_offset));
                if (got.append_len !== want.append_len)
                    report_mismatch("append_len", 32'(got.append_len), 32'(want.append_len));
                if (got.message_id !== want.message_id)
                    report_mismatch("message_id", 32'(got.message_id), 32'(want.message_id));
                if (got.message_command !== want.message_command)
                    report_mismatch("message_command", 32'(got.message_command),
                                    32'(want.message_command));
                if (got.message_bytes !== want.message_bytes)
                    report_mismatch("message_bytes", 32'(got.message_bytes),
                                    32'(want.message_bytes));
                if (got.reply_seq !== want.reply_seq)
                    report_mismatch("reply_seq", 32'(got.reply_seq), 32'(want.reply_seq));
                status_count[want.status]++;
            end
            results_checked++;
        end
    end

    // watchdog on handshake activity
    always @(posedge i_clk) begin
        if ((frame_valid && in_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("no handshake for %0d cycles, %0d results still expected",
                     quiet_cycles, expected_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic push_frame(int plen, logic [7:0] fid, logic [7:0] cmd,
                              logic [7:0] frm, logic [7:0] flen, logic [7:0] pad);
        t_frc_item it;
        it.func               = 1'b0;
        it.pdu_length         = 10'(plen);
        it.header_flags_id    = fid;
        it.header_command     = cmd;
        it.header_frames      = frm;
        it.header_payload_len = flen;
        it.pad_byte           = pad;
        pending_frames.push_back(it);
        if (plen != 0)
            frames_queued++;
    endtask

    task automatic push_timeout();
        t_frc_item   it;
        logic [63:0] noise;
        noise   = {$urandom, $urandom};
        it      = noise[$bits(t_frc_item)-1:0];
        it.func = 1'b1;
        pending_frames.push_back(it);
        frames_queued++;
    endtask

    task automatic wait_idle();
        while (pending_frames.size() != 0 || frame_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic set_key(logic v);
        wait_idle();
        @(posedge i_clk);
        cfg_we      <= 1'b1;
        cfg_wdata   <= v;
        key_setting = v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        key_writes++;
    endtask

    // one message of well-formed frames, sometimes broken, or a noise item
    task automatic queue_message();
        int         last;
        int         s;
        int         flen;
        int         plen;
        int         blocks;
        logic       enc;
        logic [3:0] id;
        logic [3:0] lst;
        logic [3:0] sq;
        logic [7:0] cmd;
        logic [7:0] pad;
        bit         broken;
        if ($urandom_range(99) < 10) begin
            if ($urandom_range(7) == 0)
                push_timeout();
            else
                push_frame(int'($urandom_range(0, 1023)), 8'($urandom), 8'($urandom),
                           8'($urandom), 8'($urandom), 8'($urandom));
            return;
        end
        last = ($urandom_range(99) < 60) ? $urandom_range(0, 3) : $urandom_range(0, 15);
        id   = 4'($urandom);
        cmd  = 8'($urandom);
        enc  = $urandom_range(99) < 40;
        for (s = 0; s <= last; s++) begin
            flen = ($urandom_range(99) < 80) ? $urandom_range(0, 64) : $urandom_range(0, 255);
            if (enc) begin
                blocks = (flen + AES_BLOCK - 1) / AES_BLOCK + $urandom_range(0, 1);
                plen   = HEADER_LEN + AES_BLOCK * blocks;
                pad    = ($urandom_range(99) < 75) ? 8'($urandom_range(1, 16)) : 8'($urandom);
            end else begin
                plen = HEADER_LEN + flen;
                pad  = 8'($urandom);
            end
            lst    = 4'(last);
            sq     = 4'(s);
            broken = $urandom_range(99) < 6;
            if (broken) begin
                case ($urandom_range(0, 6))
                    0: sq = sq + 4'($urandom_range(1, 15));
                    1: id = id ^ 4'($urandom_range(1, 15));
                    2: cmd = cmd ^ 8'($urandom_range(1, 255));
                    3: lst = lst ^ 4'($urandom_range(1, 15));
                    4: plen = plen + 1;
                    5: push_timeout();
                    default: push_frame(0, 8'($urandom), 8'($urandom), 8'($urandom),
                                        8'($urandom), 8'($urandom));
                endcase
            end
            push_frame(plen, {3'($urandom), enc, id}, cmd, {lst, sq}, 8'(flen), pad);
            if (broken && $urandom_range(1) == 1)
                return;
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no key installed yet
        push_frame(0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);     // empty frame, ignored
        push_timeout();
        push_frame(4, 8'h03, 8'h55, 8'h00, 8'd0, 8'h00);      // empty message completes
        push_frame(6, 8'h03, 8'h55, 8'h21, 8'd2, 8'h00);      // first frame with nonzero seq
        push_frame(20, 8'h1A, 8'h10, 8'h00, 8'd10, 8'h03);    // encrypted without key
        push_frame(21, 8'h1A, 8'h10, 8'h00, 8'd10, 8'h03);    // not a block multiple
        push_frame(2, 8'h01, 8'h01, 8'h00, 8'd0, 8'h00);      // short frame
        push_frame(3, 8'h11, 8'h01, 8'h00, 8'd0, 8'h00);      // short encrypted frame
        push_frame(10, 8'h02, 8'h20, 8'h00, 8'd5, 8'h00);     // length mismatch
        push_frame(259, 8'hE5, 8'hA0, 8'h20, 8'd255, 8'h00);
        push_frame(259, 8'hE5, 8'hA0, 8'h21, 8'd255, 8'h00);
        push_frame(1023, 8'hE5, 8'hA0, 8'h22, 8'd255, 8'hFF); // overflows the buffer
        push_frame(12, 8'h07, 8'h33, 8'h10, 8'd8, 8'h00);
        push_frame(12, 8'h07, 8'h34, 8'h11, 8'd8, 8'h00);     // command changes mid-message
        push_frame(259, 8'hEF, 8'hFF, 8'h10, 8'd255, 8'hFF);
        push_frame(259, 8'hEF, 8'hFF, 8'h11, 8'd255, 8'hFF);
        set_key(1'b1);
        push_frame(36, 8'h14, 8'h42, 8'h00, 8'd30, 8'd5);     // valid pad stripped
        push_frame(36, 8'h14, 8'h42, 8'h00, 8'd30, 8'd0);     // zero pad, nothing removed
        push_frame(36, 8'h14, 8'h42, 8'h00, 8'd30, 8'd200);   // pad out of range
        push_frame(20, 8'h14, 8'h42, 8'h00, 8'd5, 8'd16);     // pad longer than payload
        push_frame(260, 8'h1F, 8'hFF, 8'hF0, 8'd255, 8'd16);  // first of sixteen frames
        push_timeout();
        push_frame(20, 8'h14, 8'h42, 8'h00, 8'd17, 8'd1);     // encrypted, declared too long

        while (frames_queued < 625)
            queue_message();
        set_key(1'b0);
        while (frames_queued < 975)
            queue_message();
        set_key(1'b1);
        wait_idle();
        calm = 1'b1;
        while (frames_queued < 1325)
            queue_message();
        wait_idle();
        calm = 1'b0;
        set_key(1'b0);
        while (frames_queued < 1750)
            queue_message();

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch("results never returned, count", 32'(expected_results.size()), '0);
        $display("checked %0d results from %0d frames: %0d complete, %0d pending, %0d ignored",
                 results_checked, frames_accepted, status_count[ST_COMPLETE],
                 status_count[ST_PENDING], status_count[ST_IGNORED]);
        $display("error results: %0d, timeouts: %0d, key writes: %0d, mismatches: %0d",
                 results_checked - status_count[ST_COMPLETE] - status_count[ST_PENDING]
                 - status_count[ST_IGNORED] - status_count[ST_TIMEOUT],
                 status_count[ST_TIMEOUT], key_writes, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
